// ===== sv/lzwc_pkg.sv =====
// lzwc_pkg: shared constants, types and hash helpers for the lzw compressor
// no dependencies
package lzwc_pkg;

    localparam int CODE_BITS  = 12;
    localparam int HASH_SLOTS = 8192;
    localparam int HASH_BITS  = $clog2(HASH_SLOTS);
    localparam int BYTE_BITS  = 8;
    localparam int MAXC_BITS  = 12;
    localparam int LIM_W      = ((CODE_BITS > MAXC_BITS) ? CODE_BITS : MAXC_BITS) + 1;
    localparam int KEY_BITS   = 32;
    localparam int ENTRY_BITS = 1 + CODE_BITS + BYTE_BITS + CODE_BITS;

    localparam logic [CODE_BITS-1:0] CODE_MASK  = '1;
    localparam logic [CODE_BITS:0]   FIRST_FREE = (CODE_BITS+1)'(256);
    localparam logic [KEY_BITS-1:0]  HASH_MULT  = 32'h9E37_79B1;
    localparam logic [MAXC_BITS-1:0] MAXC_RESET = MAXC_BITS'(4095);

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 eos;
        logic                 start;
    } item_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic                 valid;
        logic [CODE_BITS-1:0] prefix;
        logic [BYTE_BITS-1:0] data_byte;
        logic [CODE_BITS-1:0] code;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_FINAL
    } back_state_t;

    function automatic logic [KEY_BITS-1:0] hash_pre(input logic [CODE_BITS-1:0] prefix,
                                                     input logic [BYTE_BITS-1:0] b);
        logic [KEY_BITS-1:0] k;
        k = KEY_BITS'({prefix, b});
        return k ^ (k >> 7);
    endfunction

    function automatic logic [HASH_BITS-1:0] hash_post(input logic [KEY_BITS-1:0] m);
        logic [KEY_BITS-1:0] k;
        k = m ^ (m >> 15);
        return k[HASH_BITS-1:0];
    endfunction

endpackage

// ===== sv/lzwc_front.sv =====
// lzwc_front: input acceptance, start-of-stream marking and item queue
// depends on lzwc_pkg
module lzwc_front
    import lzwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [BYTE_BITS-1:0] data_byte,
    input  logic                 end_of_stream,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 item_valid,
    output item_t                item,
    input  logic                 item_pop
);

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       first_reg, first_next;
    logic       push;

    assign in_ready   = (cnt_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(item_pop);
        first_next  = push ? end_of_stream : first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            first_reg  <= 1'b1;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{data_byte: data_byte, eos: end_of_stream, start: first_reg};
        end
    end

endmodule

// ===== sv/lzwc_back.sv =====
// lzwc_back: dictionary hash table, probe sequencer and code emission
// depends on lzwc_pkg
module lzwc_back
    import lzwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [MAXC_BITS-1:0] max_code,
    input  logic                 item_valid,
    input  item_t                item,
    output logic                 item_pop,
    input  logic                 out_empty,
    output logic                 res_push,
    output result_t              res
);

    entry_t mem [HASH_SLOTS];
    entry_t rd_data_reg;

    back_state_t state_reg, state_next;

    logic [CODE_BITS-1:0] prefix_reg;
    logic [BYTE_BITS-1:0] byte_reg;
    logic                 eos_reg;
    logic [KEY_BITS-1:0]  mul_reg;
    logic [HASH_BITS-1:0] probe_reg;
    logic [HASH_BITS-1:0] cnt_reg;
    logic [HASH_BITS-1:0] clr_reg;
    logic [CODE_BITS:0]   next_free_reg;

    logic [HASH_BITS-1:0] rd_addr;
    logic [HASH_BITS-1:0] wr_addr;
    entry_t               wr_data;
    logic                 wr_en;

    logic                 go;
    logic                 hit;
    logic                 miss;
    logic                 ins_ok;
    logic [HASH_BITS-1:0] hidx;
    logic [LIM_W-1:0]     max_ext, mask_ext, lim, nf_ext;

    assign go   = item_valid && out_empty;
    assign hidx = hash_post(mul_reg);
    assign hit  = rd_data_reg.valid && (rd_data_reg.prefix == prefix_reg)
                  && (rd_data_reg.data_byte == byte_reg);
    assign miss = !hit && (!rd_data_reg.valid || (cnt_reg == HASH_BITS'(HASH_SLOTS - 1)));

    always_comb
    begin
        max_ext  = LIM_W'(max_code);
        mask_ext = LIM_W'(CODE_MASK);
        lim      = (max_ext > mask_ext) ? mask_ext : max_ext;
        nf_ext   = LIM_W'(next_free_reg);
        ins_ok   = (nf_ext <= lim) && !rd_data_reg.valid;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == HASH_BITS'(HASH_SLOTS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (go && !item.start)
                    state_next = ST_HASH;
            ST_HASH:
                state_next = ST_PROBE;
            ST_PROBE:
                if (hit || miss)
                    state_next = eos_reg ? ST_FINAL : ST_IDLE;
            ST_FINAL:
                state_next = ST_CLEAR;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb
    begin
        item_pop = 1'b0;
        res_push = 1'b0;
        res      = '{code: prefix_reg, last: 1'b0};
        rd_addr  = probe_reg;
        wr_en    = 1'b0;
        wr_addr  = probe_reg;
        wr_data  = '{valid: 1'b1, prefix: prefix_reg, data_byte: byte_reg,
                     code: next_free_reg[CODE_BITS-1:0]};
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            ST_IDLE:
            begin
                item_pop = go;
                if (go && item.start && item.eos)
                begin
                    res_push = 1'b1;
                    res      = '{code: CODE_BITS'(item.data_byte), last: 1'b1};
                end
            end
            ST_HASH:
                rd_addr = hidx;
            ST_PROBE:
            begin
                rd_addr = probe_reg + 1'b1;
                if (!hit && miss)
                begin
                    res_push = 1'b1;
                    wr_en    = ins_ok;
                end
            end
            ST_FINAL:
            begin
                res_push = 1'b1;
                res      = '{code: prefix_reg, last: 1'b1};
            end
            default:
            begin
                item_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            next_free_reg <= FIRST_FREE;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_FINAL)
            begin
                next_free_reg <= FIRST_FREE;
                clr_reg       <= '0;
            end
            else if (wr_en && state_reg == ST_PROBE)
                next_free_reg <= next_free_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (go)
                begin
                    if (item.start)
                        prefix_reg <= CODE_BITS'(item.data_byte);
                    byte_reg <= item.data_byte;
                    eos_reg  <= item.eos;
                    mul_reg  <= hash_pre(prefix_reg, item.data_byte) * HASH_MULT;
                end
            ST_HASH:
            begin
                probe_reg <= hidx;
                cnt_reg   <= '0;
            end
            ST_PROBE:
            begin
                if (hit)
                    prefix_reg <= rd_data_reg.code;
                else if (miss)
                    prefix_reg <= CODE_BITS'(byte_reg);
                else
                begin
                    probe_reg <= probe_reg + 1'b1;
                    cnt_reg   <= cnt_reg + 1'b1;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // dictionary memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== sv/lzwc_out.sv =====
// lzwc_out: two-entry result queue driving the output channel
// depends on lzwc_pkg
module lzwc_out
    import lzwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_push,
    input  result_t              res,
    output logic                 out_empty,
    output logic [CODE_BITS-1:0] code_word,
    output logic                 last_code,
    output logic                 out_valid,
    input  logic                 out_ready
);

    result_t    q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_empty = (cnt_reg == 2'd0);
    assign pop       = out_valid && out_ready;
    assign code_word = q_reg[rd_ptr_reg].code;
    assign last_code = q_reg[rd_ptr_reg].last;

    always_comb
    begin
        wr_ptr_next = res_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(res_push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            q_reg[wr_ptr_reg] <= res;
    end

endmodule

// ===== sv/lzw_compressor_top.sv =====
// lzw_compressor_top: byte-stream lzw compressor, 12-bit codes
// depends on lzwc_pkg, lzwc_front, lzwc_back, lzwc_out
//
//  channel | signals                                   | direction
//  input   | in_valid/in_ready, data_byte, end_of_stream | in
//  output  | out_valid/out_ready, code_word, last_code   | out
//  config  | cfg_we, cfg_wdata (max_code)              | in
//
// the first byte of a stream is handled in the idle state; other bytes go through the
// hash and probe states, with one more probe per occupied slot passed over, and the final
// byte adds the final state; the dictionary table read is registered
// after reset and after the end of each stream of two or more bytes a pass clears
// all 8192 slots; up to two bytes are still taken into the input queue meanwhile
// a new byte is started only once the result queue is empty
module lzw_compressor_top
    import lzwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [BYTE_BITS-1:0] data_byte,
    input  logic                 end_of_stream,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic [CODE_BITS-1:0] code_word,
    output logic                 last_code,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 cfg_we,
    input  logic [MAXC_BITS-1:0] cfg_wdata
);

    logic [MAXC_BITS-1:0] max_code_reg;
    logic                 item_valid;
    item_t                item;
    logic                 item_pop;
    logic                 out_empty;
    logic                 res_push;
    result_t              res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_code_reg <= MAXC_RESET;
        else if (cfg_we)
            max_code_reg <= cfg_wdata;
    end

    lzwc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    lzwc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_code   (max_code_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .out_empty  (out_empty),
        .res_push   (res_push),
        .res        (res)
    );

    lzwc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res       (res),
        .out_empty (out_empty),
        .code_word (code_word),
        .last_code (last_code),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

// ===== sv/lzwc_checker.sv =====
// lzwc_checker: port-level checks on the lzw compressor, bound to the top level
// depends on lzwc_pkg, lzw_compressor_top
module lzwc_checker
    import lzwc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic [CODE_BITS-1:0] code_word,
    input logic                 last_code,
    input logic                 out_valid,
    input logic                 out_ready
);

    // results held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(code_word) && $stable(last_code))
        else $error("result changed while stalled");

    // queues come out of reset empty
    a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result shown right after reset");

    a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
        else $error("input not ready right after reset");

endmodule

bind lzw_compressor_top lzwc_checker u_lzwc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .code_word (code_word),
    .last_code (last_code),
    .out_valid (out_valid),
    .out_ready (out_ready)
);

// ===== sim/lzw_compressor_top_tb.sv =====
// lzw_compressor_top_tb: random and directed byte streams against an in-bench lzw predictor
// depends on lzwc_pkg and lzw_compressor_top
module lzw_compressor_top_tb;
    import lzwc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 40000000;
    localparam int CLEAR_WAIT  = 8400;

    typedef struct {
        logic [CODE_BITS-1:0] code;
        logic                 last;
    } code_exp_t;

    logic                 clk;
    logic                 rst_n;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 end_of_stream;
    logic                 in_valid;
    logic                 in_ready;
    logic [CODE_BITS-1:0] code_word;
    logic                 last_code;
    logic                 out_valid;
    logic                 out_ready;
    logic                 cfg_we;
    logic [MAXC_BITS-1:0] cfg_wdata;

    code_exp_t codes_due[$];
    int        errors;
    int        cycles;
    bit        idle_en;
    int        sent;
    int        stall_left;

    // predictor state
    bit                   slot_used [HASH_SLOTS];
    logic [CODE_BITS-1:0] slot_pfx  [HASH_SLOTS];
    logic [BYTE_BITS-1:0] slot_byte [HASH_SLOTS];
    logic [CODE_BITS-1:0] slot_code [HASH_SLOTS];
    logic [CODE_BITS-1:0] cur_prefix;
    bit                   have_prefix;
    logic [CODE_BITS:0]   next_code;
    logic [MAXC_BITS-1:0] max_code_m;

    lzw_compressor_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code_word     (code_word),
        .last_code     (last_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output stalls
    always @(posedge clk)
    begin
        if (idle_en && stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idle_en && $urandom_range(0, 5) == 0)
                stall_left <= $urandom_range(1, 11);
            else
                stall_left <= 0;
        end
    end

    task automatic report(input string msg);
        $display("error at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // result checker
    always @(negedge clk)
    begin
        code_exp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (codes_due.size() == 0)
                report($sformatf("unexpected code %0d", code_word));
            else
            begin
                e = codes_due.pop_front();
                if (code_word !== e.code)
                    report($sformatf("code_word %0d, want %0d", code_word, e.code));
                if (last_code !== e.last)
                    report($sformatf("last_code %0b, want %0b", last_code, e.last));
            end
        end
    end

    function automatic logic [HASH_BITS-1:0] slot_of(input logic [CODE_BITS-1:0] p,
                                                     input logic [BYTE_BITS-1:0] b);
        logic [31:0] k;
        k = (32'(p) << 8) | 32'(b);
        k = k ^ (k >> 7);
        k = k * 32'h9E37_79B1;
        k = k ^ (k >> 15);
        return k[HASH_BITS-1:0];
    endfunction

    task automatic dict_clear();
        for (int i = 0; i < HASH_SLOTS; i++)
            slot_used[i] = 0;
        cur_prefix  = '0;
        have_prefix = 0;
        next_code   = 13'd256;
    endtask

    task automatic predict_byte(input logic [BYTE_BITS-1:0] b, input logic eos);
        code_exp_t            e;
        int                   idx;
        int                   free_idx;
        bit                   hit;
        logic [CODE_BITS-1:0] found;
        int                   lim;
        if (!have_prefix)
        begin
            cur_prefix  = CODE_BITS'(b);
            have_prefix = 1;
        end
        else
        begin
            idx      = slot_of(cur_prefix, b);
            free_idx = HASH_SLOTS;
            hit      = 0;
            for (int n = 0; n < HASH_SLOTS; n++)
            begin
                if (!slot_used[idx])
                begin
                    free_idx = idx;
                    break;
                end
                if (slot_pfx[idx] == cur_prefix && slot_byte[idx] == b)
                begin
                    hit   = 1;
                    found = slot_code[idx];
                    break;
                end
                idx = (idx + 1) % HASH_SLOTS;
            end
            if (hit)
                cur_prefix = found;
            else
            begin
                e.code = cur_prefix;
                e.last = 1'b0;
                codes_due = {codes_due, e};
                lim = (max_code_m < 4095) ? max_code_m : 4095;
                if (next_code <= lim && free_idx < HASH_SLOTS)
                begin
                    slot_used[free_idx] = 1;
                    slot_pfx[free_idx]  = cur_prefix;
                    slot_byte[free_idx] = b;
                    slot_code[free_idx] = next_code[CODE_BITS-1:0];
                    next_code++;
                end
                cur_prefix = CODE_BITS'(b);
            end
        end
        if (eos)
        begin
            e.code = cur_prefix;
            e.last = 1'b1;
            codes_due = {codes_due, e};
            dict_clear();
        end
    endtask

    task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic eos);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
        predict_byte(b, eos);
        sent++;
    endtask

    task automatic drain();
        while (codes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max_code(input logic [MAXC_BITS-1:0] v);
        in_valid <= 1'b0;
        drain();
        repeat (CLEAR_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        max_code_m = v;
    endtask

    task automatic send_stream(input logic [BYTE_BITS-1:0] s[]);
        foreach (s[i])
            send_byte(s[i], i == s.size() - 1);
    endtask

    task automatic test_short_streams();
        send_stream('{8'h00});
        send_stream('{8'hFF});
        send_stream('{8'h00, 8'hFF});
        send_stream('{8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07});
    endtask

    task automatic test_frozen_dict();
        write_max_code(12'd256);
        send_stream('{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42});
        write_max_code(12'd255);
        send_stream('{8'h05, 8'h05, 8'h05, 8'h05});
    endtask

    task automatic random_streams(input int n_items);
        logic [BYTE_BITS-1:0] alpha[4];
        int                   len;
        int                   stop;
        int                   mode;
        logic [BYTE_BITS-1:0] b;
        stop = sent + n_items;
        while (sent < stop)
        begin
            for (int i = 0; i < 4; i++)
                alpha[i] = $urandom_range(0, 255);
            mode = $urandom_range(0, 9);
            len  = (mode == 0) ? $urandom_range(1, 3) : $urandom_range(20, 90);
            if (len > stop - sent)
                len = stop - sent;
            for (int i = 0; i < len; i++)
            begin
                if (mode == 1)
                    b = $urandom_range(0, 255);
                else
                    b = alpha[$urandom_range(0, (mode < 5) ? 1 : 3)];
                send_byte(b, i == len - 1);
            end
        end
    endtask

    task automatic test_random();
        write_max_code(12'd4095);
        random_streams(300);
        write_max_code(12'd300);
        random_streams(250);
        write_max_code(12'($urandom_range(256, 4095)));
        random_streams(200);
        write_max_code(12'($urandom_range(0, 255)));
        random_streams(120);
        write_max_code(12'd4095);
        idle_en = 0;
        random_streams(160);
    endtask

    initial
    begin
        clk           = 0;
        rst_n         = 0;
        in_valid      = 0;
        data_byte     = '0;
        end_of_stream = 0;
        out_ready     = 0;
        cfg_we        = 0;
        cfg_wdata     = '0;
        errors        = 0;
        cycles        = 0;
        sent          = 0;
        stall_left    = 0;
        idle_en       = 1;
        max_code_m    = 12'd4095;
        dict_clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_streams();
        test_frozen_dict();
        test_random();

        in_valid <= 1'b0;
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== files.f =====
sv/lzwc_pkg.sv
sv/lzwc_front.sv
sv/lzwc_back.sv
sv/lzwc_out.sv
sv/lzw_compressor_top.sv
sv/lzwc_checker.sv
sim/lzw_compressor_top_tb.sv
